/* design/bzb_pkg.sv */
// shared constants and types for the quadratic bezier bounding box pipeline
// no dependencies
package bzb_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;

  localparam int NUM_W   = COORD_WIDTH + 1;
  localparam int DEN_W   = COORD_WIDTH + 2;
  localparam int REM_W   = DEN_W + 1;
  localparam int TD_W    = T_FRAC_BITS + NUM_W + 1;
  localparam int TT_W    = 2 * T_FRAC_BITS;
  localparam int SUM_W   = 2 * T_FRAC_BITS + DEN_W + 2;
  localparam int DIV_LAT = T_FRAC_BITS + 1;
  localparam int EVAL_LAT = 4;
  localparam int LAT     = DIV_LAT + EVAL_LAT;
  localparam int AXES    = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [T_FRAC_BITS-1:0] tparam_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl_x;
    coord_t ctrl_y;
    coord_t end_x;
    coord_t end_y;
  } curve_t;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_max_x;
    coord_t box_max_y;
  } box_t;

endpackage

/* design/bzb_if.sv */
// valid/ready channel interfaces for curve input words and box result words
// depends on bzb_pkg
interface bzb_curve_if;
  logic valid;
  logic ready;
  bzb_pkg::coord_t start_x;
  bzb_pkg::coord_t start_y;
  bzb_pkg::coord_t ctrl_x;
  bzb_pkg::coord_t ctrl_y;
  bzb_pkg::coord_t end_x;
  bzb_pkg::coord_t end_y;

  modport source(output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                 input ready);
  modport sink(input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
               output ready);
endinterface

interface bzb_box_if;
  logic valid;
  logic ready;
  bzb_pkg::coord_t box_min_x;
  bzb_pkg::coord_t box_min_y;
  bzb_pkg::coord_t box_max_x;
  bzb_pkg::coord_t box_max_y;

  modport source(output valid, box_min_x, box_min_y, box_max_x, box_max_y,
                 input ready);
  modport sink(input valid, box_min_x, box_min_y, box_max_x, box_max_y,
               output ready);
endinterface

/* design/bzb_div.sv */
// extremum parameter of one axis: sign/range checks, then a pipelined
// restoring divider giving one quotient bit per stage; depends on bzb_pkg
module bzb_div (
  input  logic             clk,
  input  logic             en,
  input  bzb_pkg::coord_t  p0,
  input  bzb_pkg::coord_t  p1,
  input  bzb_pkg::coord_t  p2,
  output bzb_pkg::tparam_t t
);

  localparam int T = bzb_pkg::T_FRAC_BITS;

  logic signed [bzb_pkg::NUM_W-1:0] num;
  logic signed [bzb_pkg::DEN_W-1:0] den;
  logic signed [bzb_pkg::DEN_W-1:0] num_e;
  logic [bzb_pkg::DEN_W-1:0] an;
  logic [bzb_pkg::DEN_W-1:0] ad;
  logic ok;

  logic [bzb_pkg::REM_W-1:0] rem [0:T];
  logic [bzb_pkg::DEN_W-1:0] dvs [0:T];
  bzb_pkg::tparam_t          quo [0:T];

  assign num   = bzb_pkg::NUM_W'(p0) - bzb_pkg::NUM_W'(p1);
  assign den   = bzb_pkg::DEN_W'(p0) - (bzb_pkg::DEN_W'(p1) <<< 1) + bzb_pkg::DEN_W'(p2);
  assign num_e = bzb_pkg::DEN_W'(num);
  assign an    = num_e[bzb_pkg::DEN_W-1] ? unsigned'(-num_e) : unsigned'(num_e);
  assign ad    = den[bzb_pkg::DEN_W-1] ? unsigned'(-den) : unsigned'(den);
  assign ok    = (den != '0) && (num != '0) &&
                 (num[bzb_pkg::NUM_W-1] == den[bzb_pkg::DEN_W-1]) && (an < ad);

  // no extremum inside the curve: divide zero by one, t = 0 lands on the start point
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ok ? bzb_pkg::REM_W'(an) : '0;
      dvs[0] <= ok ? ad : bzb_pkg::DEN_W'(1);
      quo[0] <= '0;
    end
  end

  for (genvar i = 1; i <= T; i++) begin : g_step
    logic [bzb_pkg::REM_W-1:0] sh;
    logic ge;
    assign sh = {rem[i-1][bzb_pkg::REM_W-2:0], 1'b0};
    assign ge = sh >= bzb_pkg::REM_W'(dvs[i-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? sh - bzb_pkg::REM_W'(dvs[i-1]) : sh;
        dvs[i] <= dvs[i-1];
        quo[i] <= {quo[i-1][T-2:0], ge};
      end
    end
  end

  assign t = quo[T];

endmodule

/* design/bzb_eval.sv */
// evaluates the curve at both extremum parameters in both axes over three
// stages, then merges the points into the end-point box; depends on bzb_pkg
module bzb_eval (
  input  logic              clk,
  input  logic              en,
  input  bzb_pkg::curve_t   curve,
  input  bzb_pkg::tparam_t  t_x,
  input  bzb_pkg::tparam_t  t_y,
  output bzb_pkg::box_t     box
);

  localparam int T = bzb_pkg::T_FRAC_BITS;
  localparam logic signed [bzb_pkg::SUM_W-1:0] ROUND = bzb_pkg::SUM_W'(1) <<< (2 * T - 1);

  bzb_pkg::coord_t p0 [bzb_pkg::AXES];
  bzb_pkg::coord_t p1 [bzb_pkg::AXES];
  bzb_pkg::coord_t p2 [bzb_pkg::AXES];
  bzb_pkg::tparam_t tp [bzb_pkg::AXES];

  // stage 1
  logic [bzb_pkg::TT_W-1:0]                s1_tt [bzb_pkg::AXES];
  logic signed [bzb_pkg::TD_W-1:0]         s1_td [bzb_pkg::AXES][bzb_pkg::AXES];
  logic signed [bzb_pkg::DEN_W-1:0]        s1_den [bzb_pkg::AXES];
  bzb_pkg::coord_t                         s1_p0 [bzb_pkg::AXES];
  bzb_pkg::coord_t                         s1_lo [bzb_pkg::AXES];
  bzb_pkg::coord_t                         s1_hi [bzb_pkg::AXES];
  // stage 2
  logic signed [bzb_pkg::SUM_W-1:0]        s2_m  [bzb_pkg::AXES][bzb_pkg::AXES];
  logic signed [bzb_pkg::TD_W-1:0]         s2_td [bzb_pkg::AXES][bzb_pkg::AXES];
  bzb_pkg::coord_t                         s2_p0 [bzb_pkg::AXES];
  bzb_pkg::coord_t                         s2_lo [bzb_pkg::AXES];
  bzb_pkg::coord_t                         s2_hi [bzb_pkg::AXES];
  // stage 3
  bzb_pkg::coord_t                         s3_b  [bzb_pkg::AXES][bzb_pkg::AXES];
  bzb_pkg::coord_t                         s3_lo [bzb_pkg::AXES];
  bzb_pkg::coord_t                         s3_hi [bzb_pkg::AXES];
  // stage 4
  bzb_pkg::coord_t                         s4_lo [bzb_pkg::AXES];
  bzb_pkg::coord_t                         s4_hi [bzb_pkg::AXES];

  assign p0[0] = curve.start_x;
  assign p0[1] = curve.start_y;
  assign p1[0] = curve.ctrl_x;
  assign p1[1] = curve.ctrl_y;
  assign p2[0] = curve.end_x;
  assign p2[1] = curve.end_y;
  assign tp[0] = t_x;
  assign tp[1] = t_y;

  for (genvar k = 0; k < bzb_pkg::AXES; k++) begin : g_axis
    logic signed [bzb_pkg::NUM_W-1:0] d1;
    assign d1 = bzb_pkg::NUM_W'(p1[k]) - bzb_pkg::NUM_W'(p0[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        s1_tt[k]  <= bzb_pkg::TT_W'(tp[k] * tp[k]);
        s1_den[k] <= bzb_pkg::DEN_W'(p0[k]) - (bzb_pkg::DEN_W'(p1[k]) <<< 1) +
                     bzb_pkg::DEN_W'(p2[k]);
        s1_p0[k]  <= p0[k];
        s1_lo[k]  <= (p2[k] < p0[k]) ? p2[k] : p0[k];
        s1_hi[k]  <= (p2[k] > p0[k]) ? p2[k] : p0[k];
        s2_p0[k]  <= s1_p0[k];
        s2_lo[k]  <= s1_lo[k];
        s2_hi[k]  <= s1_hi[k];
        s3_lo[k]  <= s2_lo[k];
        s3_hi[k]  <= s2_hi[k];
      end
    end

    // j selects the parameter (from the x or y extremum), k the evaluated axis
    for (genvar j = 0; j < bzb_pkg::AXES; j++) begin : g_par
      logic signed [bzb_pkg::SUM_W-1:0] sum;
      assign sum = (bzb_pkg::SUM_W'(s2_td[j][k]) <<< (T + 1)) + s2_m[j][k] + ROUND;

      always_ff @(posedge clk) begin
        if (en) begin
          s1_td[j][k] <= $signed({1'b0, tp[j]}) * d1;
          s2_m[j][k]  <= $signed({1'b0, s1_tt[j]}) * s1_den[k];
          s2_td[j][k] <= s1_td[j][k];
          s3_b[j][k]  <= s2_p0[k] + sum[2*T +: bzb_pkg::COORD_WIDTH];
        end
      end
    end

    bzb_pkg::coord_t lo_a, hi_a;
    assign lo_a = (s3_b[0][k] < s3_lo[k]) ? s3_b[0][k] : s3_lo[k];
    assign hi_a = (s3_b[0][k] > s3_hi[k]) ? s3_b[0][k] : s3_hi[k];

    always_ff @(posedge clk) begin
      if (en) begin
        s4_lo[k] <= (s3_b[1][k] < lo_a) ? s3_b[1][k] : lo_a;
        s4_hi[k] <= (s3_b[1][k] > hi_a) ? s3_b[1][k] : hi_a;
      end
    end
  end

  assign box.box_min_x = s4_lo[0];
  assign box.box_min_y = s4_lo[1];
  assign box.box_max_x = s4_hi[0];
  assign box.box_max_y = s4_hi[1];

endmodule

/* design/quadratic_bezier_bounds.sv */
// top level: tight bounding box of a quadratic bezier curve, one word per cycle
// depends on bzb_pkg, bzb_if, bzb_div, bzb_eval
//
//   channel  dir  word
//   curve    in   start_x start_y ctrl_x ctrl_y end_x end_y (signed q9.6)
//   box      out  box_min_x box_min_y box_max_x box_max_y  (signed q9.6)
//
// one word enters per cycle while the pipe advances; the pipe holds the two
// bit-per-stage dividers (one check stage plus 16 quotient stages) followed
// by evaluation and merging. the whole pipe advances whenever the output
// register is empty or being taken, so a stall freezes every stage in place.
// rst clears only the valid bits.
module quadratic_bezier_bounds (
  input  logic clk,
  input  logic rst,
  bzb_curve_if.sink curve,
  bzb_box_if.source box
);

  logic advance;
  logic [bzb_pkg::LAT-1:0] vld;
  bzb_pkg::curve_t curve_in;
  bzb_pkg::curve_t dly [0:bzb_pkg::DIV_LAT-1];
  bzb_pkg::tparam_t t_x, t_y;
  bzb_pkg::box_t box_q;

  assign advance     = !vld[bzb_pkg::LAT-1] || box.ready;
  assign curve.ready = advance;

  assign curve_in.start_x = curve.start_x;
  assign curve_in.start_y = curve.start_y;
  assign curve_in.ctrl_x  = curve.ctrl_x;
  assign curve_in.ctrl_y  = curve.ctrl_y;
  assign curve_in.end_x   = curve.end_x;
  assign curve_in.end_y   = curve.end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[bzb_pkg::LAT-2:0], curve.valid};
    end
  end

  // curve word rides alongside the dividers
  always_ff @(posedge clk) begin
    if (advance) begin
      dly[0] <= curve_in;
      for (int i = 1; i < bzb_pkg::DIV_LAT; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  bzb_div u_div_x (
    .clk (clk),
    .en  (advance),
    .p0  (curve.start_x),
    .p1  (curve.ctrl_x),
    .p2  (curve.end_x),
    .t   (t_x)
  );

  bzb_div u_div_y (
    .clk (clk),
    .en  (advance),
    .p0  (curve.start_y),
    .p1  (curve.ctrl_y),
    .p2  (curve.end_y),
    .t   (t_y)
  );

  bzb_eval u_eval (
    .clk   (clk),
    .en    (advance),
    .curve (dly[bzb_pkg::DIV_LAT-1]),
    .t_x   (t_x),
    .t_y   (t_y),
    .box   (box_q)
  );

  assign box.valid     = vld[bzb_pkg::LAT-1];
  assign box.box_min_x = box_q.box_min_x;
  assign box.box_min_y = box_q.box_min_y;
  assign box.box_max_x = box_q.box_max_x;
  assign box.box_max_y = box_q.box_max_y;

endmodule
